FILE: design/btr_pkg.sv
// Shared types and constants for the brick-to-raster voxel scatter block.
// Used by btr_ctrl, btr_dpath and brick_to_raster_voxel_scatter_top.
`default_nettype none

package btr_pkg;

	localparam int MAX_EXTENT_DEF = 1024;

	// brick geometry: 8 voxels per edge
	localparam int BRICK_LOG  = 3;
	localparam int BRICK_EDGE = 1 << BRICK_LOG;

	// configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;

	// item field widths
	localparam int BYTE_W  = 8;
	localparam int COORD_W = 10;
	localparam int ADDR_W  = 30;
	localparam int COUNT_W = 31;
	localparam int SUM_W   = 38;
	localparam int SQSUM_W = 46;

	// accumulator widths (sum and square sum one bit wider than their outputs, count as wide as its output)
	localparam int CNT_ST_W = 31;
	localparam int SUM_ST_W = 39;
	localparam int SQ_ST_W  = 47;

	typedef logic [BRICK_LOG-1:0] ib_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // accept the input item, advance position
		logic row_en;   // y + extent_y * z
		logic addr_en;  // x + extent_x * row
		logic push;     // move finished result into the output register
	} btr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic keep;      // current position lies inside the extents
		logic out_free;  // output register empty or being taken
	} btr_stat_t;

endpackage

`default_nettype wire

FILE: design/btr_ctrl.sv
// Controller state machine of the voxel scatter block.
// Depends on btr_pkg; drives btr_dpath through btr_cmd_t.
`default_nettype none

module btr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire btr_pkg::btr_stat_t stat,
	output btr_pkg::btr_cmd_t       cmd
);
	import btr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_ADDR,
		ST_PUSH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// padding voxels give no item and stay here
					if (in_valid && stat.keep) begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd         = '0;
		cmd.load    = in_ready && in_valid;
		cmd.row_en  = (state_q == ST_ROW);
		cmd.addr_en = (state_q == ST_ADDR);
		cmd.push    = (state_q == ST_PUSH) && stat.out_free;
	end

endmodule

`default_nettype wire

FILE: design/btr_dpath.sv
// Datapath of the voxel scatter block: extents, brick position counters,
// accumulators, the two address multiplies and the output register. Uses btr_pkg.
`default_nettype none

module btr_dpath #(
	parameter int MAX_EXTENT = btr_pkg::MAX_EXTENT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [btr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [btr_pkg::CFG_W-1:0]       cfg_data,
	input  wire btr_pkg::btr_cmd_t               cmd,
	output btr_pkg::btr_stat_t                   stat,
	input  wire logic [btr_pkg::BYTE_W-1:0]      voxel_byte,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic [btr_pkg::COORD_W-1:0]          coord_x,
	output logic [btr_pkg::COORD_W-1:0]          coord_y,
	output logic [btr_pkg::COORD_W-1:0]          coord_z,
	output logic [btr_pkg::ADDR_W-1:0]           raster_address,
	output logic [btr_pkg::BYTE_W-1:0]           density,
	output logic [btr_pkg::COUNT_W-1:0]          voxel_count,
	output logic [btr_pkg::SUM_W-1:0]            byte_sum,
	output logic [btr_pkg::SQSUM_W-1:0]          square_sum,
	output logic                                 last_voxel
);
	import btr_pkg::*;

	localparam int CRD_W = $clog2(MAX_EXTENT);
	localparam int EXT_W = CRD_W + 1;
	localparam int BRK_W = (CRD_W > BRICK_LOG) ? CRD_W - BRICK_LOG : 1;
	localparam int POS_W = BRK_W + BRICK_LOG;
	localparam int CMP_W = (EXT_W > POS_W) ? EXT_W : POS_W;
	localparam int SQ_W  = 2 * BYTE_W;
	localparam int ZP_W  = EXT_W + POS_W;
	localparam ib_t IB_LAST = ib_t'(BRICK_EDGE - 1);

	// clamped extents
	logic [EXT_W-1:0] ex_q, ey_q, ez_q;
	logic [EXT_W-1:0] cfg_clamped;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = EXT_W'(1);
		end else if (32'(cfg_data) > MAX_EXTENT) begin
			cfg_clamped = EXT_W'(MAX_EXTENT);
		end else begin
			cfg_clamped = EXT_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_q <= EXT_W'(1);
			ey_q <= EXT_W'(1);
			ez_q <= EXT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXTENT_X: ex_q <= cfg_clamped;
				REG_EXTENT_Y: ey_q <= cfg_clamped;
				REG_EXTENT_Z: ez_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// position in brick order
	ib_t              ibx_q, iby_q, ibz_q;
	logic [BRK_W-1:0] bx_q, by_q, bz_q;
	logic [POS_W-1:0] x, y, z;

	assign x = {bx_q, ibx_q};
	assign y = {by_q, iby_q};
	assign z = {bz_q, ibz_q};

	logic [EXT_W-1:0] nbx, nby, nbz;
	logic             bx_more, by_more, bz_more;
	logic             brick_end, map_end;
	logic             keep, last;

	assign nbx = (ex_q + EXT_W'(BRICK_EDGE - 1)) >> BRICK_LOG;
	assign nby = (ey_q + EXT_W'(BRICK_EDGE - 1)) >> BRICK_LOG;
	assign nbz = (ez_q + EXT_W'(BRICK_EDGE - 1)) >> BRICK_LOG;

	assign bx_more = (EXT_W'(bx_q) + EXT_W'(1)) < nbx;
	assign by_more = (EXT_W'(by_q) + EXT_W'(1)) < nby;
	assign bz_more = (EXT_W'(bz_q) + EXT_W'(1)) < nbz;

	assign brick_end = (ibx_q == IB_LAST) && (iby_q == IB_LAST) && (ibz_q == IB_LAST);
	assign map_end   = brick_end && !bx_more && !by_more && !bz_more;

	assign keep = (CMP_W'(x) < CMP_W'(ex_q)) && (CMP_W'(y) < CMP_W'(ey_q))
		&& (CMP_W'(z) < CMP_W'(ez_q));
	assign last = (CMP_W'(x) == CMP_W'(ex_q - EXT_W'(1)))
		&& (CMP_W'(y) == CMP_W'(ey_q - EXT_W'(1)))
		&& (CMP_W'(z) == CMP_W'(ez_q - EXT_W'(1)));

	// accumulators
	logic [CNT_ST_W-1:0]  cnt_q, cnt_nx;
	logic [SUM_ST_W-1:0]  sum_q, sum_nx;
	logic [SQ_ST_W-1:0]   sq_q, sq_nx;
	logic [SQ_W-1:0]      byte_sq;

	assign byte_sq = SQ_W'(voxel_byte) * SQ_W'(voxel_byte);
	assign cnt_nx  = keep ? cnt_q + CNT_ST_W'(1) : cnt_q;
	assign sum_nx  = keep ? sum_q + SUM_ST_W'(voxel_byte) : sum_q;
	assign sq_nx   = keep ? sq_q + SQ_ST_W'(byte_sq) : sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibx_q <= '0;
			iby_q <= '0;
			ibz_q <= '0;
			bx_q  <= '0;
			by_q  <= '0;
			bz_q  <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
		end else if (cmd.load) begin
			ibx_q <= ibx_q + ib_t'(1);
			if (ibx_q == IB_LAST) begin
				iby_q <= iby_q + ib_t'(1);
				if (iby_q == IB_LAST) begin
					ibz_q <= ibz_q + ib_t'(1);
				end
			end
			if (brick_end) begin
				if (bx_more) begin
					bx_q <= bx_q + BRK_W'(1);
				end else begin
					bx_q <= '0;
					if (by_more) begin
						by_q <= by_q + BRK_W'(1);
					end else begin
						by_q <= '0;
						if (bz_more) begin
							bz_q <= bz_q + BRK_W'(1);
						end else begin
							bz_q <= '0;
						end
					end
				end
			end
			// the map's final byte starts a fresh map
			if (map_end) begin
				cnt_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
			end else begin
				cnt_q <= cnt_nx;
				sum_q <= sum_nx;
				sq_q  <= sq_nx;
			end
		end
	end

	// stage 1: captured voxel, held until pushed
	logic [POS_W-1:0]    x_s1, y_s1, z_s1;
	logic [BYTE_W-1:0]   val_s1;
	logic [CNT_ST_W-1:0] cnt_s1;
	logic [SUM_ST_W-1:0] sum_s1;
	logic [SQ_ST_W-1:0]  sq_s1;
	logic                last_s1;

	always_ff @(posedge clk) begin
		if (cmd.load && keep) begin
			x_s1    <= x;
			y_s1    <= y;
			z_s1    <= z;
			val_s1  <= voxel_byte;
			cnt_s1  <= cnt_nx;
			sum_s1  <= sum_nx;
			sq_s1   <= sq_nx;
			last_s1 <= last;
		end
	end

	// stage 2: row = y + extent_y * z; stage 3: addr = x + extent_x * row
	logic [ZP_W-1:0]   zprod;
	logic [ADDR_W-1:0] aprod;
	logic [ADDR_W-1:0] row_s2, addr_s3;

	// the address wraps at its width, so only the low product bits matter
	assign zprod = ZP_W'(ey_q) * ZP_W'(z_s1);
	assign aprod = ADDR_W'(ex_q) * row_s2;

	always_ff @(posedge clk) begin
		if (cmd.row_en) begin
			row_s2 <= ADDR_W'(y_s1) + ADDR_W'(zprod);
		end
		if (cmd.addr_en) begin
			addr_s3 <= aprod + ADDR_W'(x_s1);
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			coord_x        <= COORD_W'(x_s1);
			coord_y        <= COORD_W'(y_s1);
			coord_z        <= COORD_W'(z_s1);
			raster_address <= addr_s3;
			density        <= val_s1;
			voxel_count    <= COUNT_W'(cnt_s1);
			byte_sum       <= SUM_W'(sum_s1);
			square_sum     <= SQSUM_W'(sq_s1);
			last_voxel     <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.keep     = keep;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

FILE: design/brick_to_raster_voxel_scatter_top.sv
// Top level of the brick-to-raster voxel scatter block.
// Instantiates btr_ctrl and btr_dpath; uses btr_pkg.
//
//   channel   signals                        direction
//   in        in_valid / in_ready            byte stream in, brick order
//   out       out_valid / out_ready          one item per kept voxel
//   cfg       cfg_we / cfg_index / cfg_data  extent registers, write only
//
// A padding voxel is accepted and gives no item. A kept voxel steps through accept,
// y + extent_y*z, x + extent_x*row and hand-off; the two multiplies share no stage.
// The output register lets the next byte in while an item waits; a stalled output
// holds the hand-off step. Reset clears the position, accumulators and output
// valid; extents reset to 1.
`default_nettype none

module brick_to_raster_voxel_scatter_top #(
	parameter int MAX_EXTENT = btr_pkg::MAX_EXTENT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [btr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [btr_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [btr_pkg::BYTE_W-1:0]    voxel_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [btr_pkg::COORD_W-1:0]        coord_x,
	output logic [btr_pkg::COORD_W-1:0]        coord_y,
	output logic [btr_pkg::COORD_W-1:0]        coord_z,
	output logic [btr_pkg::ADDR_W-1:0]         raster_address,
	output logic [btr_pkg::BYTE_W-1:0]         density,
	output logic [btr_pkg::COUNT_W-1:0]        voxel_count,
	output logic [btr_pkg::SUM_W-1:0]          byte_sum,
	output logic [btr_pkg::SQSUM_W-1:0]        square_sum,
	output logic                               last_voxel
);
	import btr_pkg::*;

	btr_cmd_t  cmd;
	btr_stat_t stat;

	btr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	btr_dpath #(
		.MAX_EXTENT (MAX_EXTENT)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.stat           (stat),
		.voxel_byte     (voxel_byte),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.raster_address (raster_address),
		.density        (density),
		.voxel_count    (voxel_count),
		.byte_sum       (byte_sum),
		.square_sum     (square_sum),
		.last_voxel     (last_voxel)
	);

`ifndef SYNTHESIS
	// a push never overwrites an item that is still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid || out_ready))
		else $error("push into occupied output register");

	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid)
		else $error("pushed item not presented");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.row_en, cmd.addr_en, cmd.push}))
		else $error("controller commands overlap");

	// no new byte while a kept voxel is still in the address chain
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && stat.keep) |=> !in_ready)
		else $error("input accepted while address chain busy");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/brick_to_raster_voxel_scatter_top_tb.sv
// Self-checking bench for brick_to_raster_voxel_scatter_top: feeds a brick-ordered byte
// stream, tracks position, extents and running sums alongside, checks every voxel item.
// Depends on btr_pkg and the design sources.
module brick_to_raster_voxel_scatter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import btr_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_BYTES  = 1750;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AT       = 60;
	localparam int IDLE_PCT      = 13;
	localparam int MAX_REPORTS   = 10;
	localparam int BRICK_IDX_W   = 7;
	// stretches with no idling, counted in bytes taken and in items received
	localparam int IN_CALM_FROM  = 700;
	localparam int IN_CALM_TO    = 1000;
	localparam int OUT_CALM_FROM = 150;
	localparam int OUT_CALM_TO   = 300;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cz;
		logic [ADDR_W-1:0]  addr;
		logic [BYTE_W-1:0]  density;
		logic [COUNT_W-1:0] kept;
		logic [SUM_W-1:0]   byte_total;
		logic [SQSUM_W-1:0] square_total;
		logic               last_flag;
	} raster_voxel_t;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
		logic [BYTE_W-1:0]    value;
		logic                 typed;
		raster_voxel_t        want;
	} stim_row_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic [BYTE_W-1:0]    voxel_byte = '0;
	logic                 out_ready  = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic [COORD_W-1:0]   coord_x;
	logic [COORD_W-1:0]   coord_y;
	logic [COORD_W-1:0]   coord_z;
	logic [ADDR_W-1:0]    raster_address;
	logic [BYTE_W-1:0]    density;
	logic [COUNT_W-1:0]   voxel_count;
	logic [SUM_W-1:0]     byte_sum;
	logic [SQSUM_W-1:0]   square_sum;
	logic                 last_voxel;

	brick_to_raster_voxel_scatter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.voxel_byte    (voxel_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.coord_z       (coord_z),
		.raster_address(raster_address),
		.density       (density),
		.voxel_count   (voxel_count),
		.byte_sum      (byte_sum),
		.square_sum    (square_sum),
		.last_voxel    (last_voxel)
	);

	always #HALF_PERIOD clk = ~clk;

	// scatter state kept alongside the block, at its reset values
	logic [CFG_W-1:0]       extent_reg [0:2] = '{11'd1, 11'd1, 11'd1};
	logic [BRICK_LOG-1:0]   vox_x = '0, vox_y = '0, vox_z = '0;
	logic [BRICK_IDX_W-1:0] brk_x = '0, brk_y = '0, brk_z = '0;
	logic [CNT_ST_W-1:0]    kept_total   = '0;
	logic [SUM_ST_W-1:0]    byte_acc     = '0;
	logic [SQ_ST_W-1:0]     square_acc   = '0;

	raster_voxel_t pending_voxels [$];
	int bytes_taken    = 0;
	int voxels_checked = 0;
	int mismatches     = 0;
	int extent_writes  = 0;

	function automatic int unsigned effective_extent(input logic [CFG_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > MAX_EXTENT_DEF)
			return MAX_EXTENT_DEF;
		return 32'(r);
	endfunction

	function automatic int unsigned bricks_along(input int unsigned e);
		return (e + BRICK_EDGE - 1) / BRICK_EDGE;
	endfunction

	// one byte through the scatter: the voxel item it gives, if kept, and the next position
	task automatic scatter_voxel(input logic [BYTE_W-1:0] b, output logic is_kept,
			output raster_voxel_t v);
		int unsigned ex, ey, ez, x, y, z;
		longint unsigned addr;
		ex = effective_extent(extent_reg[REG_EXTENT_X]);
		ey = effective_extent(extent_reg[REG_EXTENT_Y]);
		ez = effective_extent(extent_reg[REG_EXTENT_Z]);
		x = brk_x * BRICK_EDGE + vox_x;
		y = brk_y * BRICK_EDGE + vox_y;
		z = brk_z * BRICK_EDGE + vox_z;
		is_kept = 1'b0;
		v = '0;
		if (x < ex && y < ey && z < ez) begin
			addr = longint'(x) + longint'(ex) * (longint'(y) + longint'(ey) * longint'(z));
			kept_total = kept_total + 1'b1;
			byte_acc   = byte_acc + b;
			square_acc = square_acc + b * b;
			v.cx           = x[COORD_W-1:0];
			v.cy           = y[COORD_W-1:0];
			v.cz           = z[COORD_W-1:0];
			v.addr         = addr[ADDR_W-1:0];
			v.density      = b;
			v.kept         = kept_total[COUNT_W-1:0];
			v.byte_total   = byte_acc[SUM_W-1:0];
			v.square_total = square_acc[SQSUM_W-1:0];
			v.last_flag    = (x == ex - 1) && (y == ey - 1) && (z == ez - 1);
			is_kept = 1'b1;
		end
		vox_x = vox_x + 1'b1;
		if (vox_x == 0) begin
			vox_y = vox_y + 1'b1;
			if (vox_y == 0) begin
				vox_z = vox_z + 1'b1;
				if (vox_z == 0) begin
					// brick boundary: a shrunken extent wraps an index that is past it
					if (brk_x + 1 < bricks_along(ex)) begin
						brk_x = brk_x + 1'b1;
					end else begin
						brk_x = '0;
						if (brk_y + 1 < bricks_along(ey)) begin
							brk_y = brk_y + 1'b1;
						end else begin
							brk_y = '0;
							if (brk_z + 1 < bricks_along(ez)) begin
								brk_z = brk_z + 1'b1;
							end else begin
								brk_z      = '0;
								kept_total = '0;
								byte_acc   = '0;
								square_acc = '0;
							end
						end
					end
				end
			end
		end
	endtask

	function automatic raster_voxel_t voxel_of(input int x, input int y, input int z,
			input int addr, input int b, input int n, input longint s, input longint q,
			input logic last);
		raster_voxel_t v;
		v.cx           = COORD_W'(x);
		v.cy           = COORD_W'(y);
		v.cz           = COORD_W'(z);
		v.addr         = ADDR_W'(addr);
		v.density      = BYTE_W'(b);
		v.kept         = COUNT_W'(n);
		v.byte_total   = SUM_W'(s);
		v.square_total = SQSUM_W'(q);
		v.last_flag    = last;
		return v;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] d);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.index  = idx;
		r.data   = d;
		return r;
	endfunction

	function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] b, input logic typed,
			input raster_voxel_t want);
		stim_row_t r;
		r = '0;
		r.value = b;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] pick_extent();
		logic [CFG_W-1:0] e;
		case ($urandom_range(19))
			0: e = '0;
			1: e = CFG_W'($urandom_range(MAX_EXTENT_DEF + 1, (1 << CFG_W) - 1));
			2: e = CFG_W'($urandom_range(1, MAX_EXTENT_DEF));
			3, 4, 5: e = CFG_W'(BRICK_EDGE);
			6, 7: e = CFG_W'($urandom_range(1, 2 * BRICK_EDGE));
			default: e = CFG_W'($urandom_range(1, BRICK_EDGE));
		endcase
		return e;
	endfunction

	function automatic string voxel_text(input raster_voxel_t v);
		return $sformatf("(%0d,%0d,%0d) addr=%0d byte=%0d n=%0d sum=%0d sq=%0d last=%0b",
			v.cx, v.cy, v.cz, v.addr, v.density, v.kept, v.byte_total, v.square_total,
			v.last_flag);
	endfunction

	function automatic void check_voxel();
		raster_voxel_t got, want;
		got.cx           = coord_x;
		got.cy           = coord_y;
		got.cz           = coord_z;
		got.addr         = raster_address;
		got.density      = density;
		got.kept         = voxel_count;
		got.byte_total   = byte_sum;
		got.square_total = square_sum;
		got.last_flag    = last_voxel;
		voxels_checked++;
		if (pending_voxels.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("item %0d not expected: %s", voxels_checked, voxel_text(got));
			return;
		end
		want = pending_voxels.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("item %0d mismatch, expected %s", voxels_checked, voxel_text(want));
				$display("item %0d mismatch, actual   %s", voxels_checked, voxel_text(got));
			end
		end
	endfunction

	task automatic write_extent(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		if (idx != REG_SPARE)
			extent_reg[idx] = d;
		extent_writes++;
	endtask

	// wait until every kept voxel is out and padding bytes have drained
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_voxels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
			input raster_voxel_t want);
		int gap;
		logic is_kept;
		raster_voxel_t v;
		gap = 0;
		if (bytes_taken < IN_CALM_FROM || bytes_taken >= IN_CALM_TO)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		cfg_we <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		voxel_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_taken++;
		scatter_voxel(b, is_kept, v);
		if (typed)
			pending_voxels.push_back(want);
		else if (is_kept)
			pending_voxels.push_back(v);
	endtask

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_voxel();
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held && voxels_checked >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if ((voxels_checked < OUT_CALM_FROM || voxels_checked >= OUT_CALM_TO)
					&& $urandom_range(99) < IDLE_PCT) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("no item moved for %0d cycles", STALL_LIMIT);
		$display("brick_to_raster_voxel_scatter_top_tb: errors");
		$finish;
	end

	initial begin
		stim_row_t rows [$];
		int random_sent;
		int phase_len;
		logic [CFG_IDX_W-1:0] idx;
		random_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extents 1x1x1 out of reset: the origin is the whole map
		rows.push_back(byte_row(8'hFF, 1'b1, voxel_of(0, 0, 0, 0, 255, 1, 255, 65025, 1'b1)));
		rows.push_back(byte_row(8'h00, 1'b0, '0));
		// mid-map: all-ones clamps to the max, zero counts as one
		rows.push_back(cfg_row(REG_EXTENT_X, 11'h7FF));
		rows.push_back(cfg_row(REG_EXTENT_Y, 11'd1024));
		rows.push_back(cfg_row(REG_EXTENT_Z, 11'h000));
		rows.push_back(byte_row(8'h00, 1'b1, voxel_of(2, 0, 0, 2, 0, 2, 255, 65025, 1'b0)));
		rows.push_back(byte_row(8'h01, 1'b0, '0));
		rows.push_back(byte_row(8'h80, 1'b0, '0));
		rows.push_back(byte_row(8'h7F, 1'b0, '0));
		rows.push_back(byte_row(8'hFE, 1'b0, '0));
		rows.push_back(byte_row(8'hAA, 1'b0, '0));
		rows.push_back(byte_row(8'h55, 1'b0, '0));
		rows.push_back(cfg_row(REG_SPARE, 11'h7FF));
		rows.push_back(cfg_row(REG_EXTENT_Z, 11'd1025));
		rows.push_back(byte_row(8'h33, 1'b0, '0));
		rows.push_back(byte_row(8'hCC, 1'b0, '0));
		rows.push_back(byte_row(8'h0F, 1'b0, '0));
		rows.push_back(byte_row(8'hF0, 1'b0, '0));
		rows.push_back(byte_row(8'h5A, 1'b0, '0));
		// shrink below the current position
		rows.push_back(cfg_row(REG_EXTENT_X, 11'd3));
		rows.push_back(cfg_row(REG_EXTENT_Y, 11'd2));
		rows.push_back(cfg_row(REG_EXTENT_Z, 11'd1));
		rows.push_back(byte_row(8'hC3, 1'b0, '0));
		rows.push_back(byte_row(8'h3C, 1'b0, '0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				if (!cfg_we)
					settle();
				write_extent(rows[i].index, rows[i].data);
			end else begin
				send_byte(rows[i].value, rows[i].typed, rows[i].want);
			end
		end

		while (random_sent < RANDOM_BYTES) begin
			settle();
			if ($urandom_range(4) == 0) begin
				// one write to a single index, possibly the spare one, while the map is under way
				idx = CFG_IDX_W'($urandom_range(REG_SPARE));
				write_extent(idx, pick_extent());
			end else begin
				write_extent(REG_EXTENT_X, pick_extent());
				write_extent(REG_EXTENT_Y, pick_extent());
				write_extent(REG_EXTENT_Z, pick_extent());
			end
			phase_len = $urandom_range(100, 600);
			for (int k = 0; k < phase_len && random_sent < RANDOM_BYTES; k++) begin
				send_byte(BYTE_W'($urandom_range(255)), 1'b0, '0);
				random_sent++;
			end
		end

		settle();
		$display("run covered %0d bytes, %0d voxel items, %0d extent writes, %0d mismatches",
			bytes_taken, voxels_checked, extent_writes, mismatches);
		if (mismatches == 0 && pending_voxels.size() == 0)
			$display("brick_to_raster_voxel_scatter_top_tb: clean");
		else
			$display("brick_to_raster_voxel_scatter_top_tb: errors");
		$finish;
	end

endmodule

FILE: sim.f
design/btr_pkg.sv
design/btr_ctrl.sv
design/btr_dpath.sv
design/brick_to_raster_voxel_scatter_top.sv
tb/sv/brick_to_raster_voxel_scatter_top_tb.sv
